@@ rtl/core/lru_write_back_block_cache_core_assert.svh @@
// Assertion macros used by the cache core RTL.
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_CORE_ASSERT_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define LWBC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define LWBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lwbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lwbc_pkg
// Types and codes of the LRU write-back block cache tag controller.
// ----------------------------------------------------------------------------
package lwbc_pkg;

   localparam int CACHE_ENTRIES = 32;

   localparam logic [2:0] CMD_GET_READ    = 3'd0;
   localparam logic [2:0] CMD_GET_WRITE   = 3'd1;
   localparam logic [2:0] CMD_FLUSH_DIRTY = 3'd2;
   localparam logic [2:0] CMD_FLUSH_FORCE = 3'd3;
   localparam logic [2:0] CMD_FLUSH_ALL   = 3'd4;
   localparam logic [2:0] CMD_INIT        = 3'd5;

   localparam logic [1:0] ACT_GRANT      = 2'd0;
   localparam logic [1:0] ACT_WRITE_BACK = 2'd1;
   localparam logic [1:0] ACT_FETCH      = 2'd2;
   localparam logic [1:0] ACT_DONE       = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] block_number;
      logic [7:0]  device_number;
      logic [4:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  slot;
      logic [31:0] block_number_out;
      logic [7:0]  device_out;
      logic        hit;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] block;
      logic [7:0]  device;
   } tag_type;

endpackage

@@ rtl/core/lwbc_tag_ram.sv @@
// ----------------------------------------------------------------------------
// lwbc_tag_ram
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lwbc_tag_ram #(
   parameter int DEPTH = lwbc_pkg::CACHE_ENTRIES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  lwbc_pkg::tag_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output lwbc_pkg::tag_type rd_data
);

   lwbc_pkg::tag_type mem [DEPTH];
   lwbc_pkg::tag_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lru_write_back_block_cache_core.sv @@
// ----------------------------------------------------------------------------
// lru_write_back_block_cache_core
// Fully associative LRU write-back cache tag controller, tags in a RAM.
// ----------------------------------------------------------------------------
//  channel | ports                       | dir | moves
//  req     | req_valid req_ready req_item | in  | one command item
//  rsp     | rsp_valid rsp_ready rsp_item | out | write back / fetch / grant / done
//
//  One item at a time. A get scans the tag RAM one entry a cycle and stops at a
//  match; on a miss the LRU victim is written back if dirty, then fetched.
//  Flush all walks the recency order, one position a cycle except where a
//  write back is sent (and may stall), then done. Flush slot writes back at
//  most one slot; init and unknown codes only return done.
//  Reset and init clear valid, dirty and the recency ranks at once.
//  A stalled rsp holds the current item; the sequencer waits for it.
// ----------------------------------------------------------------------------
module lru_write_back_block_cache_core #(
   parameter int CACHE_ENTRIES = lwbc_pkg::CACHE_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lwbc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lwbc_pkg::rsp_type rsp_item
);

   localparam int SW = $clog2(CACHE_ENTRIES);
   localparam logic [SW-1:0] LAST_RANK = SW'(CACHE_ENTRIES - 1);
   localparam logic [SW:0]   NUM_ENT   = (SW+1)'(CACHE_ENTRIES);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SCAN   = 9'b000000010,
      ST_VICTIM = 9'b000000100,
      ST_WB     = 9'b000001000,
      ST_FETCH  = 9'b000010000,
      ST_GRANT  = 9'b000100000,
      ST_FSLOT  = 9'b001000000,
      ST_FALL   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   lwbc_pkg::req_type cur_ff;
   logic [SW:0]       idx_ff;
   logic              pend_ff;
   logic [SW-1:0]     pend_slot_ff;
   logic [SW-1:0]     slot_ff;
   logic [SW-1:0]     pos_ff;
   logic              hit_ff;
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic [CACHE_ENTRIES-1:0] dirty_ff;
   logic [SW-1:0]     rank_ff [CACHE_ENTRIES];
   logic              rsp_valid_ff;
   lwbc_pkg::rsp_type rsp_ff;

   logic              out_free;
   logic              emit;
   lwbc_pkg::rsp_type emit_data;
   logic              rd_en;
   logic [SW-1:0]     rd_addr;
   lwbc_pkg::tag_type rd_data;
   logic              wr_en;
   lwbc_pkg::tag_type wr_data;
   logic [SW-1:0]     sel_target;
   logic [SW-1:0]     sel_slot;
   logic              hit_now;
   logic              is_get;
   logic              is_write;
   logic              fs_in_range;
   logic [SW-1:0]     fs_slot;
   logic              lru_touch;
   logic [SW-1:0]     touch_rank;

   lwbc_tag_ram #(
      .DEPTH (CACHE_ENTRIES),
      .AW    (SW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign is_get   = (cur_ff.command == lwbc_pkg::CMD_GET_READ) ||
                     (cur_ff.command == lwbc_pkg::CMD_GET_WRITE);
   assign is_write = (cur_ff.command == lwbc_pkg::CMD_GET_WRITE);
   assign fs_in_range = ({2'b00, cur_ff.slot_index} < 7'(CACHE_ENTRIES));
   assign fs_slot     = SW'(cur_ff.slot_index);

   assign wr_data.block  = cur_ff.block_number;
   assign wr_data.device = cur_ff.device_number;

   assign hit_now = pend_ff && valid_ff[pend_slot_ff] &&
                    (rd_data.block == cur_ff.block_number) &&
                    (rd_data.device == cur_ff.device_number);

   // slot whose rank equals the target position
   assign sel_target = (state_ff == ST_FALL) ? pos_ff : LAST_RANK;
   always_comb begin
      sel_slot = '0;
      for (int j = 0; j < CACHE_ENTRIES; j++) begin
         if (rank_ff[j] == sel_target) begin
            sel_slot = SW'(j);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      emit      = 1'b0;
      emit_data = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      lru_touch = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority case (req_item.command)
                  lwbc_pkg::CMD_GET_READ,
                  lwbc_pkg::CMD_GET_WRITE:   state_in = ST_SCAN;
                  lwbc_pkg::CMD_FLUSH_DIRTY,
                  lwbc_pkg::CMD_FLUSH_FORCE: state_in = ST_FSLOT;
                  lwbc_pkg::CMD_FLUSH_ALL:   state_in = ST_FALL;
                  default:                   state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            rd_en   = (idx_ff < NUM_ENT);
            rd_addr = idx_ff[SW-1:0];
            if (hit_now) begin
               state_in = ST_GRANT;
            end else if (!rd_en) begin
               state_in = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            rd_addr = sel_slot;
            if (valid_ff[sel_slot] && dirty_ff[sel_slot]) begin
               rd_en    = 1'b1;
               state_in = ST_WB;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_WB: begin
            if (out_free) begin
               emit                       = 1'b1;
               emit_data.action           = lwbc_pkg::ACT_WRITE_BACK;
               emit_data.slot             = 5'(slot_ff);
               emit_data.block_number_out = rd_data.block;
               emit_data.device_out       = rd_data.device;
               if (is_get) begin
                  state_in = ST_FETCH;
               end else if (cur_ff.command == lwbc_pkg::CMD_FLUSH_ALL &&
                            pos_ff != LAST_RANK) begin
                  state_in = ST_FALL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FETCH: begin
            if (out_free) begin
               emit                       = 1'b1;
               wr_en                      = 1'b1;
               lru_touch                  = 1'b1;
               emit_data.action           = lwbc_pkg::ACT_FETCH;
               emit_data.slot             = 5'(slot_ff);
               emit_data.block_number_out = cur_ff.block_number;
               emit_data.device_out       = cur_ff.device_number;
               state_in                   = ST_GRANT;
            end
         end
         ST_GRANT: begin
            if (out_free) begin
               emit                       = 1'b1;
               lru_touch                  = hit_ff;
               emit_data.action           = lwbc_pkg::ACT_GRANT;
               emit_data.slot             = 5'(slot_ff);
               emit_data.block_number_out = cur_ff.block_number;
               emit_data.device_out       = cur_ff.device_number;
               emit_data.hit              = hit_ff;
               emit_data.last             = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         ST_FSLOT: begin
            rd_addr = fs_slot;
            if (fs_in_range && valid_ff[fs_slot] &&
                (cur_ff.command == lwbc_pkg::CMD_FLUSH_FORCE || dirty_ff[fs_slot])) begin
               rd_en    = 1'b1;
               state_in = ST_WB;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FALL: begin
            rd_addr = sel_slot;
            if (valid_ff[sel_slot] && dirty_ff[sel_slot]) begin
               rd_en    = 1'b1;
               state_in = ST_WB;
            end else if (pos_ff == LAST_RANK) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_data.action = lwbc_pkg::ACT_DONE;
               emit_data.last   = 1'b1;
               if (cur_ff.command == lwbc_pkg::CMD_FLUSH_DIRTY ||
                   cur_ff.command == lwbc_pkg::CMD_FLUSH_FORCE) begin
                  emit_data.slot = cur_ff.slot_index;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign touch_rank = rank_ff[slot_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         pend_ff      <= 1'b0;
         for (int j = 0; j < CACHE_ENTRIES; j++) begin
            rank_ff[j] <= SW'(j);
         end
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && req_valid &&
             req_item.command == lwbc_pkg::CMD_INIT) begin
            valid_ff <= '0;
            dirty_ff <= '0;
            for (int j = 0; j < CACHE_ENTRIES; j++) begin
               rank_ff[j] <= SW'(j);
            end
         end
         if (state_ff == ST_IDLE) begin
            pend_ff <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            pend_ff <= rd_en;
         end
         if (state_ff == ST_WB && emit) begin
            dirty_ff[slot_ff] <= 1'b0;
         end
         if (state_ff == ST_FETCH && emit) begin
            valid_ff[slot_ff] <= 1'b1;
            dirty_ff[slot_ff] <= is_write;
         end
         if (state_ff == ST_GRANT && emit && hit_ff && is_write) begin
            dirty_ff[slot_ff] <= 1'b1;
         end
         // move slot_ff to most recent
         if (lru_touch) begin
            for (int j = 0; j < CACHE_ENTRIES; j++) begin
               if (rank_ff[j] < touch_rank) begin
                  rank_ff[j] <= rank_ff[j] + 1'b1;
               end
            end
            rank_ff[slot_ff] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= emit_data;
      end
      if (state_ff == ST_IDLE) begin
         cur_ff <= req_item;
         idx_ff <= '0;
         pos_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (rd_en) begin
            idx_ff <= idx_ff + 1'b1;
         end
         pend_slot_ff <= rd_addr;
         if (hit_now) begin
            slot_ff <= pend_slot_ff;
            hit_ff  <= 1'b1;
         end
      end
      if (state_ff == ST_VICTIM) begin
         slot_ff <= sel_slot;
         hit_ff  <= 1'b0;
      end
      if (state_ff == ST_FSLOT) begin
         slot_ff <= fs_slot;
      end
      if (state_ff == ST_FALL) begin
         slot_ff <= sel_slot;
         if (!rd_en && pos_ff != LAST_RANK) begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
      if (state_ff == ST_WB && emit && pos_ff != LAST_RANK) begin
         pos_ff <= pos_ff + 1'b1;
      end
   end

`include "lru_write_back_block_cache_core_assert.svh"

   `LWBC_ASSERT_NOW(a_wb_not_last, clock, reset, rsp_valid_ff && rsp_ff.action == lwbc_pkg::ACT_WRITE_BACK, !rsp_ff.last && !rsp_ff.hit, "write back item marked last or hit")
   `LWBC_ASSERT_NOW(a_done_clean, clock, reset, rsp_valid_ff && rsp_ff.action == lwbc_pkg::ACT_DONE, rsp_ff.last && !rsp_ff.hit && rsp_ff.block_number_out == 32'd0, "done item malformed")
   `LWBC_ASSERT_NEXT(a_get_scans, clock, reset, req_valid && req_ready && (req_item.command == lwbc_pkg::CMD_GET_READ || req_item.command == lwbc_pkg::CMD_GET_WRITE), state_ff == ST_SCAN, "get did not start tag scan")
   `LWBC_ASSERT_NEXT(a_fetch_valid, clock, reset, state_ff == ST_FETCH && out_free, valid_ff[slot_ff] && rank_ff[slot_ff] == '0, "fetched entry not valid and most recent")

endmodule

@@ tb/sv/tb_lru_write_back_block_cache_core.sv @@
// ----------------------------------------------------------------------------
// tb_lru_write_back_block_cache_core
// Drives get, flush and init commands into the cache tag controller, predicts
// every write back, fetch, grant and done item from a behavioral copy of the
// tags and recency order, and checks each response item in order.
// ----------------------------------------------------------------------------
module tb_lru_write_back_block_cache_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NENT = lwbc_pkg::CACHE_ENTRIES;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lwbc_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lwbc_pkg::rsp_type rsp_item;

   lru_write_back_block_cache_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow tag store
   logic [31:0] tag_blk [NENT];
   logic [7:0]  tag_dev [NENT];
   logic        tag_vld [NENT];
   logic        tag_dty [NENT];
   logic [4:0]  lru_pos [NENT];

   lwbc_pkg::req_type pending_cmds[$];
   lwbc_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      rsp_count = 0;
   int      hit_count = 0;
   int      wb_count = 0;
   bit      stim_done = 1'b0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void clear_tags(logic [7:0] dev);
      for (int i = 0; i < NENT; i++) begin
         tag_blk[i] = '0;
         tag_dev[i] = dev;
         tag_vld[i] = 1'b0;
         tag_dty[i] = 1'b0;
         lru_pos[i] = 5'(i);
      end
   endfunction

   function automatic void push_rsp(logic [1:0] act, logic [4:0] s, logic [31:0] b,
                                    logic [7:0] d, logic h, logic l);
      lwbc_pkg::rsp_type r;
      r.action = act; r.slot = s; r.block_number_out = b;
      r.device_out = d; r.hit = h; r.last = l;
      expected_rsps.push_back(r);
   endfunction

   function automatic void touch(int p);
      logic [4:0] s;
      s = lru_pos[p];
      for (int q = p; q > 0; q--) lru_pos[q] = lru_pos[q-1];
      lru_pos[0] = s;
   endfunction

   function automatic void write_back_if(int s, bit need_dirty);
      if (!tag_vld[s] || (need_dirty && !tag_dty[s])) return;
      push_rsp(lwbc_pkg::ACT_WRITE_BACK, 5'(s), tag_blk[s], tag_dev[s], 1'b0, 1'b0);
      tag_dty[s] = 1'b0;
   endfunction

   function automatic void predict_cache(lwbc_pkg::req_type c);
      int s;
      if (c.command == lwbc_pkg::CMD_GET_READ || c.command == lwbc_pkg::CMD_GET_WRITE) begin
         for (int p = 0; p < NENT; p++) begin
            s = int'(lru_pos[p]);
            if (tag_vld[s] && tag_blk[s] == c.block_number &&
                tag_dev[s] == c.device_number) begin
               touch(p);
               if (c.command == lwbc_pkg::CMD_GET_WRITE) tag_dty[s] = 1'b1;
               push_rsp(lwbc_pkg::ACT_GRANT, 5'(s), c.block_number, c.device_number,
                        1'b1, 1'b1);
               return;
            end
         end
         s = int'(lru_pos[NENT-1]);
         write_back_if(s, 1'b1);
         touch(NENT-1);
         tag_blk[s] = c.block_number;
         tag_dev[s] = c.device_number;
         tag_vld[s] = 1'b1;
         tag_dty[s] = (c.command == lwbc_pkg::CMD_GET_WRITE);
         push_rsp(lwbc_pkg::ACT_FETCH, 5'(s), c.block_number, c.device_number, 1'b0, 1'b0);
         push_rsp(lwbc_pkg::ACT_GRANT, 5'(s), c.block_number, c.device_number, 1'b0, 1'b1);
      end else if (c.command == lwbc_pkg::CMD_FLUSH_DIRTY ||
                   c.command == lwbc_pkg::CMD_FLUSH_FORCE) begin
         if (int'(c.slot_index) < NENT)
            write_back_if(int'(c.slot_index), c.command == lwbc_pkg::CMD_FLUSH_DIRTY);
         push_rsp(lwbc_pkg::ACT_DONE, c.slot_index, '0, '0, 1'b0, 1'b1);
      end else if (c.command == lwbc_pkg::CMD_FLUSH_ALL) begin
         for (int p = 0; p < NENT; p++) write_back_if(int'(lru_pos[p]), 1'b1);
         push_rsp(lwbc_pkg::ACT_DONE, '0, '0, '0, 1'b0, 1'b1);
      end else begin
         if (c.command == lwbc_pkg::CMD_INIT) clear_tags(c.device_number);
         push_rsp(lwbc_pkg::ACT_DONE, '0, '0, '0, 1'b0, 1'b1);
      end
   endfunction

   // small working set of blocks so gets hit often and LRU eviction kicks in
   logic [31:0] hot_blk [48];
   logic [7:0]  hot_dev [48];

   function automatic lwbc_pkg::req_type make_cmd(logic [2:0] cmd, logic [31:0] b,
                                                  logic [7:0] d, logic [4:0] s);
      lwbc_pkg::req_type c;
      c.command = cmd; c.block_number = b; c.device_number = d; c.slot_index = s;
      return c;
   endfunction

   function automatic lwbc_pkg::req_type rand_cmd();
      int r, k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 47);
      if (r < 70)
         return make_cmd((r & 1) ? lwbc_pkg::CMD_GET_WRITE : lwbc_pkg::CMD_GET_READ,
                         (r < 62) ? hot_blk[k] : $urandom, (r < 62) ? hot_dev[k] : 8'($urandom),
                         5'($urandom));
      if (r < 80)
         return make_cmd(lwbc_pkg::CMD_FLUSH_DIRTY, $urandom, 8'($urandom), 5'($urandom));
      if (r < 88)
         return make_cmd(lwbc_pkg::CMD_FLUSH_FORCE, $urandom, 8'($urandom), 5'($urandom));
      if (r < 94)
         return make_cmd(lwbc_pkg::CMD_FLUSH_ALL, $urandom, 8'($urandom), 5'($urandom));
      if (r < 97)
         return make_cmd(lwbc_pkg::CMD_INIT, $urandom, 8'($urandom), 5'($urandom));
      return make_cmd(3'($urandom_range(6, 7)), $urandom, 8'($urandom), 5'($urandom));
   endfunction

   initial begin
      for (int i = 0; i < 48; i++) begin
         hot_blk[i] = (i < 4) ? {32{i[0]}} : $urandom;
         hot_dev[i] = (i < 4) ? {8{i[1]}} : 8'($urandom_range(0, 3));
      end
      // directed: extremes, every command, invalid-entry match, last-slot flush
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_READ, 32'h0, 8'h00, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_WRITE, 32'hFFFF_FFFF, 8'hFF, 5'd31));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_READ, 32'hFFFF_FFFF, 8'hFF, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_READ, 32'hFFFF_FFFF, 8'h00, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_WRITE, 32'h0, 8'h00, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_DIRTY, 32'h0, 8'h0, 5'd31));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_DIRTY, 32'h0, 8'h0, 5'd30));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_DIRTY, 32'h0, 8'h0, 5'd31));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_FORCE, 32'hFFFF_FFFF, 8'hFF, 5'd31));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_FORCE, 32'h0, 8'h0, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_ALL, 32'h0, 8'h0, 5'd0));
      for (int i = 0; i < 34; i++)                                        // eviction wrap
         pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_WRITE, 32'(i * 7 + 1), 8'(i),
                                         5'(i)));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_FLUSH_ALL, 32'hFFFF_FFFF, 8'hFF, 5'd31));
      pending_cmds.push_back(make_cmd(3'd6, 32'hFFFF_FFFF, 8'hFF, 5'd31));
      pending_cmds.push_back(make_cmd(3'd7, 32'h0, 8'h0, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_INIT, 32'h0, 8'hFF, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_GET_READ, 32'h0, 8'hFF, 5'd0));
      pending_cmds.push_back(make_cmd(lwbc_pkg::CMD_INIT, 32'hFFFF_FFFF, 8'h00, 5'd31));
      for (int i = 0; i < 420; i++) pending_cmds.push_back(rand_cmd());
   end

   // driver: an item counts as taken at the rising edge before this falling edge
   int   req_gap = 0;
   int   cmd_count = 0;
   logic req_taken = 1'b0;

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            predict_cache(req_item);
            cmd_count <= cmd_count + 1;
         end
         if (!req_valid || req_taken) begin
            if (req_gap > 0 || pending_cmds.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap <= req_gap - 1;
               else stim_done <= (pending_cmds.size() == 0);
            end else begin
               req_item <= pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_gap <= gap_len();
            end
         end
         rsp_ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response item act=%0d slot=%0d blk=%h dev=%h hit=%b last=%b",
                     $time, rsp_item.action, rsp_item.slot, rsp_item.block_number_out,
                     rsp_item.device_out, rsp_item.hit, rsp_item.last);
            errors <= errors + 1;
         end else begin
            lwbc_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (e.action == lwbc_pkg::ACT_GRANT && e.hit) hit_count <= hit_count + 1;
            if (e.action == lwbc_pkg::ACT_WRITE_BACK) wb_count <= wb_count + 1;
            if (rsp_item !== e) begin
               $display("%0t: mismatch exp act=%0d slot=%0d blk=%h dev=%h hit=%b last=%b",
                        $time, e.action, e.slot, e.block_number_out, e.device_out,
                        e.hit, e.last);
               $display("%0t:          got act=%0d slot=%0d blk=%h dev=%h hit=%b last=%b",
                        $time, rsp_item.action, rsp_item.slot, rsp_item.block_number_out,
                        rsp_item.device_out, rsp_item.hit, rsp_item.last);
               errors <= errors + 1;
            end
         end
      end
   end

   initial begin
      clear_tags(8'h00);
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (stim_done && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      $display("Ran %0d commands, checked %0d response items (%0d hits, %0d write backs).",
               cmd_count, rsp_count, hit_count, wb_count);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d response items outstanding.", expected_rsps.size());
      $display("FAIL");
      $finish;
   end
endmodule
